@@ design/ohtbl_pkg.sv @@
// shared constants, codes and types of the object handle table
package ohtbl_pkg;

  localparam int SLOT_COUNT   = 256;
  localparam int CACHED_NAMES = 65536;

  localparam int SLOT_AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CACHE_AW = (CACHED_NAMES > 1) ? $clog2(CACHED_NAMES) : 1;
  localparam int FF_W     = SLOT_AW + 1;

  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NULL    = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [SLOT_AW-1:0] slot;
  } cache_entry_t;

  typedef struct packed {
    logic                en;
    logic [CACHE_AW-1:0] idx;
    cache_entry_t        entry;
  } cache_wr_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    logic [31:0]        name;
  } slot_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREAD,
    S_SEARCH,
    S_ALLOC,
    S_ADV,
    S_REMOVE,
    S_DONE
  } ohtbl_state_t;

endpackage

@@ design/ohtbl_slot_mem.sv @@
// slot name memory, one read and one write port, empty after reset
module ohtbl_slot_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ohtbl_pkg::SLOT_AW-1:0] rd_addr,
  input  ohtbl_pkg::slot_wr_t           wr,
  output logic [31:0]                   rd_name
);

  logic [31:0]                     mem [ohtbl_pkg::SLOT_COUNT];
  logic [ohtbl_pkg::SLOT_COUNT-1:0] vld_r;
  logic [31:0]                     rd_data_r;
  logic                            rd_vld_r;

  // an entry never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr.en) begin
      mem[wr.addr] <= wr.name;
    end
  end

  assign rd_name = rd_vld_r ? rd_data_r : 32'd0;

endmodule

@@ design/ohtbl_cache_mem.sv @@
// direct-mapped name cache memory with a clearing sweep after reset
module ohtbl_cache_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ohtbl_pkg::CACHE_AW-1:0] rd_idx,
  input  ohtbl_pkg::cache_wr_t           wr,
  output ohtbl_pkg::cache_entry_t        rd_entry,
  output logic                           init_done
);

  ohtbl_pkg::cache_entry_t          mem [ohtbl_pkg::CACHED_NAMES];
  ohtbl_pkg::cache_entry_t          rd_data_r;
  logic [ohtbl_pkg::CACHE_AW-1:0]   clr_idx_r;
  logic [ohtbl_pkg::CACHE_AW-1:0]   clr_idx_nxt;
  logic                             clr_busy_r;
  logic                             clr_busy_nxt;
  logic                             mem_we;
  logic [ohtbl_pkg::CACHE_AW-1:0]   mem_idx;
  ohtbl_pkg::cache_entry_t          mem_data;

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + ohtbl_pkg::CACHE_AW'(1);
      if (clr_idx_r == ohtbl_pkg::CACHE_AW'(ohtbl_pkg::CACHED_NAMES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // the sweep owns the write port until every entry is invalid
  assign mem_we   = clr_busy_r | wr.en;
  assign mem_idx  = clr_busy_r ? clr_idx_r : wr.idx;
  assign mem_data = clr_busy_r ? '0 : wr.entry;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
    if (mem_we) begin
      mem[mem_idx] <= mem_data;
    end
  end

  assign rd_entry  = rd_data_r;
  assign init_done = !clr_busy_r;

endmodule

@@ design/object_handle_table.sv @@
// object handle table: sequencer over the slot memory and the name cache
// a cached find or get passes IDLE, CREAD and DONE (result out, next item in); a null name goes from IDLE to DONE
// a slot search or a first-free advance reads one slot at a time, up to 256 slots each
// the slot memory and cache each give one read per cycle, which paces every walk
// one item at a time; the next item is taken while the last result waits at the output
// after reset the cache is cleared entry by entry before the first item is taken
module object_handle_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_object_name,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_slot_index,
  output logic [2:0]  out_status
);

  localparam int AW = ohtbl_pkg::SLOT_AW;
  localparam int FW = ohtbl_pkg::FF_W;

  ohtbl_pkg::ohtbl_state_t state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   name_r, name_nxt;
  logic          cacheable_r, cacheable_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [FW-1:0] ff_r, ff_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;
  logic [2:0]    out_status_r, out_status_nxt;

  logic                     in_cacheable;
  logic [AW-1:0]            slot_rd_addr;
  logic [31:0]              slot_rd_name;
  ohtbl_pkg::slot_wr_t      slot_wr;
  ohtbl_pkg::cache_wr_t     cache_wr;
  ohtbl_pkg::cache_entry_t  cache_rd;
  logic                     init_done;
  logic                     accept;

  assign in_cacheable = in_object_name < 32'(ohtbl_pkg::CACHED_NAMES);
  assign in_stall     = !(state_r == ohtbl_pkg::S_IDLE && init_done);
  assign accept       = in_valid && !in_stall;

  ohtbl_slot_mem u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (slot_rd_addr),
    .wr      (slot_wr),
    .rd_name (slot_rd_name)
  );

  ohtbl_cache_mem u_cache_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (in_object_name[ohtbl_pkg::CACHE_AW-1:0]),
    .wr        (cache_wr),
    .rd_entry  (cache_rd),
    .init_done (init_done)
  );

  // every write lands before the next read of the same entry,
  // since each write state leads on through DONE to IDLE
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    name_nxt       = name_r;
    cacheable_nxt  = cacheable_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    ff_nxt         = ff_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    slot_rd_addr   = cnt_r[AW-1:0] + AW'(1);
    slot_wr        = '0;
    cache_wr       = '0;

    unique case (state_r)
      ohtbl_pkg::S_IDLE: begin
        slot_rd_addr = '0;
        if (accept) begin
          mode_nxt      = in_mode;
          name_nxt      = in_object_name;
          cacheable_nxt = in_cacheable;
          slot_nxt      = '0;
          cnt_nxt       = '0;
          if (in_object_name == 32'd0) begin
            status_nxt = ohtbl_pkg::ST_NULL;
            state_nxt  = ohtbl_pkg::S_DONE;
          end else if (in_mode != ohtbl_pkg::MODE_FIND && in_mode != ohtbl_pkg::MODE_GET &&
                       in_mode != ohtbl_pkg::MODE_REMOVE) begin
            status_nxt = ohtbl_pkg::ST_MISSING;
            state_nxt  = ohtbl_pkg::S_DONE;
          end else if (in_cacheable) begin
            state_nxt = ohtbl_pkg::S_CREAD;
          end else begin
            state_nxt = ohtbl_pkg::S_SEARCH;
          end
        end
      end

      ohtbl_pkg::S_CREAD: begin
        slot_rd_addr = '0;
        if (cache_rd.valid) begin
          slot_nxt = cache_rd.slot;
          if (mode_r == ohtbl_pkg::MODE_REMOVE) begin
            state_nxt = ohtbl_pkg::S_REMOVE;
          end else begin
            status_nxt = ohtbl_pkg::ST_FOUND;
            state_nxt  = ohtbl_pkg::S_DONE;
          end
        end else if (mode_r == ohtbl_pkg::MODE_GET) begin
          state_nxt = ohtbl_pkg::S_ALLOC;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ohtbl_pkg::S_SEARCH;
        end
      end

      // data of slot cnt arrives while slot cnt+1 is read
      ohtbl_pkg::S_SEARCH: begin
        if (slot_rd_name == name_r) begin
          slot_nxt = cnt_r[AW-1:0];
          if (mode_r == ohtbl_pkg::MODE_REMOVE) begin
            state_nxt = ohtbl_pkg::S_REMOVE;
          end else begin
            if (cacheable_r && mode_r == ohtbl_pkg::MODE_FIND) begin
              cache_wr.en          = 1'b1;
              cache_wr.idx         = name_r[ohtbl_pkg::CACHE_AW-1:0];
              cache_wr.entry.valid = 1'b1;
              cache_wr.entry.slot  = cnt_r[AW-1:0];
            end
            status_nxt = ohtbl_pkg::ST_FOUND;
            state_nxt  = ohtbl_pkg::S_DONE;
          end
        end else if (cnt_r == FW'(ohtbl_pkg::SLOT_COUNT - 1)) begin
          if (mode_r == ohtbl_pkg::MODE_GET) begin
            state_nxt = ohtbl_pkg::S_ALLOC;
          end else begin
            slot_nxt   = '0;
            status_nxt = ohtbl_pkg::ST_MISSING;
            state_nxt  = ohtbl_pkg::S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + FW'(1);
        end
      end

      ohtbl_pkg::S_ALLOC: begin
        slot_rd_addr = ff_r[AW-1:0] + AW'(1);
        if (ff_r >= FW'(ohtbl_pkg::SLOT_COUNT)) begin
          slot_nxt   = '0;
          status_nxt = ohtbl_pkg::ST_FULL;
          state_nxt  = ohtbl_pkg::S_DONE;
        end else begin
          slot_wr.en   = 1'b1;
          slot_wr.addr = ff_r[AW-1:0];
          slot_wr.name = name_r;
          if (cacheable_r) begin
            cache_wr.en          = 1'b1;
            cache_wr.idx         = name_r[ohtbl_pkg::CACHE_AW-1:0];
            cache_wr.entry.valid = 1'b1;
            cache_wr.entry.slot  = ff_r[AW-1:0];
          end
          slot_nxt   = ff_r[AW-1:0];
          status_nxt = ohtbl_pkg::ST_NEW;
          if (ff_r == FW'(ohtbl_pkg::SLOT_COUNT - 1)) begin
            ff_nxt    = FW'(ohtbl_pkg::SLOT_COUNT);
            state_nxt = ohtbl_pkg::S_DONE;
          end else begin
            cnt_nxt   = ff_r + FW'(1);
            state_nxt = ohtbl_pkg::S_ADV;
          end
        end
      end

      // walk first-free past occupied slots
      ohtbl_pkg::S_ADV: begin
        if (slot_rd_name == 32'd0) begin
          ff_nxt    = cnt_r;
          state_nxt = ohtbl_pkg::S_DONE;
        end else if (cnt_r == FW'(ohtbl_pkg::SLOT_COUNT - 1)) begin
          ff_nxt    = FW'(ohtbl_pkg::SLOT_COUNT);
          state_nxt = ohtbl_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + FW'(1);
        end
      end

      ohtbl_pkg::S_REMOVE: begin
        slot_wr.en   = 1'b1;
        slot_wr.addr = slot_r;
        slot_wr.name = 32'd0;
        if (cacheable_r) begin
          cache_wr.en    = 1'b1;
          cache_wr.idx   = name_r[ohtbl_pkg::CACHE_AW-1:0];
          cache_wr.entry = '0;
        end
        if (ff_r > {1'b0, slot_r}) begin
          ff_nxt = {1'b0, slot_r};
        end
        status_nxt = ohtbl_pkg::ST_FOUND;
        state_nxt  = ohtbl_pkg::S_DONE;
      end

      ohtbl_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (status_r == ohtbl_pkg::ST_FOUND || status_r == ohtbl_pkg::ST_NEW) begin
            out_slot_nxt = 8'(slot_r);
          end else begin
            out_slot_nxt = 8'd0;
          end
          state_nxt = ohtbl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ohtbl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ohtbl_pkg::S_IDLE;
      ff_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ff_r        <= ff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    name_r       <= name_nxt;
    cacheable_r  <= cacheable_nxt;
    cnt_r        <= cnt_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_status     = out_status_r;

  a_ff_range: assert property (@(posedge clk) disable iff (!rst_n)
    ff_r <= FW'(ohtbl_pkg::SLOT_COUNT))
    else $error("first-free pointer beyond table");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ohtbl_pkg::ST_FOUND && out_status_r != ohtbl_pkg::ST_NEW
    |-> out_slot_r == 8'd0)
    else $error("nonzero slot on a failed lookup");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second item taken while one is in work");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ohtbl_pkg::S_IDLE |-> !slot_wr.en && !cache_wr.en)
    else $error("memory write with no item in work");

  a_null_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_object_name == 32'd0 |=> status_nxt == ohtbl_pkg::ST_NULL)
    else $error("null name not reported as null");

endmodule

@@ verif/tb_object_handle_table.sv @@
// testbench for the object handle table: random find, get and remove items checked against a predictor
class handle_scoreboard;
  typedef struct {
    logic [7:0] slot;
    logic [2:0] status;
  } answer_t;

  bit [31:0]                     slot_names [ohtbl_pkg::SLOT_COUNT];
  bit                            cache_valid [ohtbl_pkg::CACHED_NAMES];
  logic [ohtbl_pkg::SLOT_AW-1:0] cache_slot [ohtbl_pkg::CACHED_NAMES];
  int                            first_free;
  answer_t                       pending_answers[$];
  int                            errors;

  // cache first, then a linear walk over the slots that fills the cache for a cacheable name
  function bit search_slots(logic [31:0] name, bit cacheable, output int slot);
    logic [ohtbl_pkg::CACHE_AW-1:0] idx;
    idx  = name[ohtbl_pkg::CACHE_AW-1:0];
    slot = 0;
    if (cacheable && cache_valid[idx]) begin
      slot = int'(cache_slot[idx]);
      return 1'b1;
    end
    for (int i = 0; i < ohtbl_pkg::SLOT_COUNT; i++) begin
      if (slot_names[i] == name) begin
        if (cacheable) begin
          cache_valid[idx] = 1'b1;
          cache_slot[idx]  = i[ohtbl_pkg::SLOT_AW-1:0];
        end
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function answer_t predict_answer(logic [1:0] mode, logic [31:0] name);
    answer_t                        ans;
    bit                             cacheable;
    int                             slot;
    logic [ohtbl_pkg::CACHE_AW-1:0] idx;
    cacheable  = name < ohtbl_pkg::CACHED_NAMES;
    idx        = name[ohtbl_pkg::CACHE_AW-1:0];
    slot       = 0;
    ans.status = ohtbl_pkg::ST_MISSING;
    if (name == 32'd0) begin
      ans.status = ohtbl_pkg::ST_NULL;
    end else begin
      case (mode)
        ohtbl_pkg::MODE_FIND: begin
          ans.status = search_slots(name, cacheable, slot) ? ohtbl_pkg::ST_FOUND :
                                                             ohtbl_pkg::ST_MISSING;
        end
        ohtbl_pkg::MODE_GET: begin
          if (cacheable && cache_valid[idx]) begin
            slot       = int'(cache_slot[idx]);
            ans.status = ohtbl_pkg::ST_FOUND;
          end else if (!cacheable && search_slots(name, 1'b0, slot)) begin
            ans.status = ohtbl_pkg::ST_FOUND;
          end else if (first_free >= ohtbl_pkg::SLOT_COUNT) begin
            ans.status = ohtbl_pkg::ST_FULL;
          end else begin
            // a cacheable name missing from the cache is allocated without a search
            slot             = first_free;
            slot_names[slot] = name;
            if (cacheable) begin
              cache_valid[idx] = 1'b1;
              cache_slot[idx]  = slot[ohtbl_pkg::SLOT_AW-1:0];
            end
            while (first_free < ohtbl_pkg::SLOT_COUNT && slot_names[first_free] != 0)
              first_free++;
            ans.status = ohtbl_pkg::ST_NEW;
          end
        end
        ohtbl_pkg::MODE_REMOVE: begin
          if (search_slots(name, cacheable, slot)) begin
            slot_names[slot] = 32'd0;
            if (cacheable)
              cache_valid[idx] = 1'b0;
            if (first_free > slot)
              first_free = slot;
            ans.status = ohtbl_pkg::ST_FOUND;
          end
        end
        default: begin
          ans.status = ohtbl_pkg::ST_MISSING;
        end
      endcase
    end
    ans.slot = (ans.status == ohtbl_pkg::ST_FOUND || ans.status == ohtbl_pkg::ST_NEW) ?
               slot[7:0] : 8'd0;
    return ans;
  endfunction

  function void note_request(logic [1:0] mode, logic [31:0] name);
    pending_answers.push_back(predict_answer(mode, name));
  endfunction

  function void check_answer(logic [7:0] slot, logic [2:0] status);
    answer_t want;
    if (pending_answers.size() == 0) begin
      $error("result slot_index=%0d status=%0d with no item waiting", slot, status);
      errors++;
      return;
    end
    want = pending_answers.pop_front();
    if (slot !== want.slot) begin
      $error("slot_index: expected %0d, actual %0d", want.slot, slot);
      errors++;
    end
    if (status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status);
      errors++;
    end
  endfunction

  function int pending();
    return pending_answers.size();
  endfunction
endclass

module tb_object_handle_table;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NAME_POOL = 320;
  localparam int STALL_LIMIT = 300000;  // covers the cache clear after reset
  localparam int TAIL_CYCLES = 600;     // longer than a full search plus a full advance

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = ohtbl_pkg::MODE_FIND;
  logic [31:0] in_object_name = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_slot_index;
  logic [2:0]  out_status;

  handle_scoreboard sb;
  logic [31:0]      name_pool [NAME_POOL];
  bit               idle_en = 1'b0;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  object_handle_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_object_name (in_object_name),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_status     (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls at random while idle_en is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0)
        out_stall <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_answer(out_slot_index, out_status);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [31:0] name);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_object_name <= name;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_request(mode, name);
  endtask

  task automatic maybe_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // sender holds off until every answer is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  function automatic logic [1:0] pick_mode(int w_find, int w_get, int w_remove);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_find)
      return ohtbl_pkg::MODE_FIND;
    else if (r < w_find + w_get)
      return ohtbl_pkg::MODE_GET;
    else if (r < w_find + w_get + w_remove)
      return ohtbl_pkg::MODE_REMOVE;
    return MODE_UNUSED;
  endfunction

  function automatic logic [31:0] pick_name();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return 32'd0;
    else if (r < 8)
      return $urandom();
    return name_pool[$urandom_range(0, NAME_POOL - 1)];
  endfunction

  task automatic run_mixed(int count, int w_find, int w_get, int w_remove);
    repeat (count) begin
      maybe_gap();
      send_item(pick_mode(w_find, w_get, w_remove), pick_name());
    end
  endtask

  initial begin
    int k;
    sb = new();
    // half the pool hits the cache, half needs a slot walk
    for (int i = 0; i < NAME_POOL; i++) begin
      if (i < NAME_POOL / 2)
        name_pool[i] = $urandom_range(1, ohtbl_pkg::CACHED_NAMES - 1);
      else
        name_pool[i] = $urandom_range(ohtbl_pkg::CACHED_NAMES, 32'hFFFF_FFFF);
    end
    name_pool[0]             = ohtbl_pkg::CACHED_NAMES - 1;
    name_pool[NAME_POOL / 2] = ohtbl_pkg::CACHED_NAMES;
    name_pool[NAME_POOL - 1] = 32'hFFFF_FFFF;

    repeat (8) @(posedge clk);
    rst_n   <= 1'b1;
    idle_en = 1'b1;

    // directed: null names, unused mode, edges of the cacheable range, reuse of freed slots
    send_item(ohtbl_pkg::MODE_FIND, 32'd0);
    send_item(ohtbl_pkg::MODE_GET, 32'd0);
    send_item(ohtbl_pkg::MODE_REMOVE, 32'd0);
    send_item(MODE_UNUSED, 32'd0);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF);
    send_item(ohtbl_pkg::MODE_FIND, 32'd1);
    send_item(ohtbl_pkg::MODE_FIND, 32'hFFFF_FFFF);
    send_item(ohtbl_pkg::MODE_GET, 32'd1);
    send_item(ohtbl_pkg::MODE_GET, ohtbl_pkg::CACHED_NAMES - 1);
    send_item(ohtbl_pkg::MODE_GET, ohtbl_pkg::CACHED_NAMES);
    send_item(ohtbl_pkg::MODE_GET, 32'hFFFF_FFFF);
    send_item(ohtbl_pkg::MODE_GET, 32'd1);
    send_item(ohtbl_pkg::MODE_GET, 32'hFFFF_FFFF);
    send_item(ohtbl_pkg::MODE_FIND, ohtbl_pkg::CACHED_NAMES - 1);
    send_item(ohtbl_pkg::MODE_FIND, ohtbl_pkg::CACHED_NAMES);
    send_item(ohtbl_pkg::MODE_REMOVE, 32'd1);
    send_item(ohtbl_pkg::MODE_REMOVE, 32'd1);
    send_item(ohtbl_pkg::MODE_FIND, 32'd1);
    send_item(ohtbl_pkg::MODE_GET, 32'h8000_0000);
    send_item(ohtbl_pkg::MODE_REMOVE, ohtbl_pkg::CACHED_NAMES);
    send_item(ohtbl_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    send_item(ohtbl_pkg::MODE_GET, 32'h5555_AAAA);
    send_item(MODE_UNUSED, 32'h0000_1234);
    drain();

    // fill the table with fresh names, then push on while it is full
    k = 0;
    while (sb.first_free < ohtbl_pkg::SLOT_COUNT) begin
      maybe_gap();
      if ($urandom_range(0, 9) != 0) begin
        send_item(ohtbl_pkg::MODE_GET, name_pool[k % NAME_POOL]);
        k++;
      end else begin
        send_item(pick_mode(30, 30, 30), pick_name());
      end
    end
    run_mixed(40, 10, 80, 10);
    drain();

    run_mixed(450, 30, 35, 30);
    drain();
    run_mixed(150, 20, 15, 60);
    drain();

    idle_en = 1'b0;
    run_mixed(230, 30, 35, 30);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
